[rtl/sit_pkg.sv]
// ============================================================================
// sit_pkg: symbol intern table package
// Shared types, result codes and default sizes for the symbol intern table.
// ============================================================================
package sit_pkg;

  // Default sizes
  localparam int unsigned MaxEntries = 128;
  localparam int unsigned MaxLen     = 64;

  // Fixed payload widths
  localparam int unsigned CharW   = 8;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned StatusW = 2;

  // Result codes
  typedef enum logic [StatusW-1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // Input transaction payload
  typedef struct packed {
    logic [CharW-1:0] char_byte;
    logic             last_char;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [IndexW-1:0] entry_index;
    status_e           status;
  } out_item_t;

  // Controller states
  typedef enum logic [2:0] {
    S_COLLECT,
    S_LEN_RD,
    S_LEN_CMP,
    S_BYTE_RD,
    S_BYTE_CMP,
    S_COPY_RD,
    S_COPY_WR,
    S_RESPOND
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    take_char;     // store an accepted character
    logic    search_start;  // rewind entry walk
    logic    next_entry;    // advance to the next stored entry
    logic    byte_start;    // rewind byte position
    logic    byte_next;     // advance byte position
    logic    copy_wr;       // write one pending byte into the entry store
    logic    ins_commit;    // write length, bump entry count
    logic    set_res;       // capture result code and index
    status_e res_code;
    logic    load_out;      // move captured result to the output register
    logic    clear_pending; // empty the pending lexeme
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic overlong_now;
    logic idx_at_count;
    logic table_full;
    logic len_eq;
    logic byte_eq;
    logic last_byte;
    logic out_busy;
  } sts_t;

endpackage

[rtl/sit_ram.sv]
// ============================================================================
// sit_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ============================================================================
module sit_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sit_datapath.sv]
// ============================================================================
// sit_datapath: symbol intern table datapath
// Pending lexeme buffer, entry stores, walk counters, compare logic and the
// output register.
// ============================================================================
module sit_datapath #(
  parameter int unsigned MAX_ENTRIES = sit_pkg::MaxEntries,
  parameter int unsigned MAX_LEN     = sit_pkg::MaxLen
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sit_pkg::CharW-1:0]   char_byte_i,
  input  sit_pkg::cmd_t               cmd_i,
  output sit_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output sit_pkg::out_item_t          out_item_o
);

  localparam int unsigned PLW    = $clog2(MAX_LEN + 1);
  localparam int unsigned PAW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW     = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IAW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CDEPTH = MAX_ENTRIES * MAX_LEN;
  localparam int unsigned CAW    = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
  localparam int unsigned CBW    = $clog2(CDEPTH + 1);

  localparam logic [PLW-1:0] LenMax   = PLW'(MAX_LEN);
  localparam logic [CW-1:0]  CountMax = CW'(MAX_ENTRIES);
  localparam logic [CBW-1:0] BaseStep = CBW'(MAX_LEN);

  logic [PLW-1:0] plen_q, plen_d;
  logic           overlong_q, overlong_d;
  logic [CW-1:0]  count_q, count_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CBW-1:0] base_q, base_d;
  logic [PAW-1:0] j_q, j_d;
  logic           out_valid_q, out_valid_d;

  sit_pkg::status_e   res_status_q;
  logic [CW-1:0]      res_index_q;
  sit_pkg::out_item_t out_item_q;

  logic                      pend_we;
  logic [sit_pkg::CharW-1:0] pend_rdata;
  logic [sit_pkg::CharW-1:0] char_rdata;
  logic [PLW-1:0]            len_rdata;
  logic [CAW-1:0]            char_addr;
  logic                      has_room;

  // Address of the current byte of the current entry
  assign char_addr = CAW'(base_q + CBW'(j_q));
  assign has_room  = (plen_q != LenMax);
  assign pend_we   = cmd_i.take_char && has_room;

  // Pending lexeme buffer
  sit_ram #(
    .Width(sit_pkg::CharW),
    .Depth(MAX_LEN)
  ) u_pend_ram (
    .clk_i  (clk_i),
    .we_i   (pend_we),
    .waddr_i(plen_q[PAW-1:0]),
    .wdata_i(char_byte_i),
    .raddr_i(j_q),
    .rdata_o(pend_rdata)
  );

  // Stored entry bytes, one row of MAX_LEN per entry
  sit_ram #(
    .Width(sit_pkg::CharW),
    .Depth(CDEPTH)
  ) u_char_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.copy_wr),
    .waddr_i(char_addr),
    .wdata_i(pend_rdata),
    .raddr_i(char_addr),
    .rdata_o(char_rdata)
  );

  // Stored entry lengths
  sit_ram #(
    .Width(PLW),
    .Depth(MAX_ENTRIES)
  ) u_len_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ins_commit),
    .waddr_i(idx_q[IAW-1:0]),
    .wdata_i(plen_q),
    .raddr_i(idx_q[IAW-1:0]),
    .rdata_o(len_rdata)
  );

  // Counter next values
  always_comb begin
    plen_d      = plen_q;
    overlong_d  = overlong_q;
    count_d     = count_q;
    idx_d       = idx_q;
    base_d      = base_q;
    j_d         = j_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.take_char) begin
      if (has_room) begin
        plen_d = plen_q + PLW'(1);
      end else begin
        overlong_d = 1'b1;
      end
    end
    if (cmd_i.clear_pending) begin
      plen_d     = '0;
      overlong_d = 1'b0;
    end
    if (cmd_i.search_start) begin
      idx_d  = '0;
      base_d = '0;
    end
    if (cmd_i.next_entry) begin
      idx_d  = idx_q + CW'(1);
      base_d = base_q + BaseStep;
    end
    if (cmd_i.byte_start) begin
      j_d = '0;
    end
    if (cmd_i.byte_next) begin
      j_d = j_q + PAW'(1);
    end
    if (cmd_i.ins_commit) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      overlong_q  <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      base_q      <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      plen_q      <= plen_d;
      overlong_q  <= overlong_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      base_q      <= base_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result capture and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_code;
      if (cmd_i.res_code == sit_pkg::ST_FOUND || cmd_i.res_code == sit_pkg::ST_INSERTED) begin
        res_index_q <= idx_q;
      end else begin
        res_index_q <= '0;
      end
    end
    if (cmd_i.load_out) begin
      out_item_q.entry_index <= sit_pkg::IndexW'(res_index_q);
      out_item_q.status      <= res_status_q;
    end
  end

  // Status to the controller
  assign sts_o.overlong_now = overlong_q || !has_room;
  assign sts_o.idx_at_count = (idx_q == count_q);
  assign sts_o.table_full   = (count_q == CountMax);
  assign sts_o.len_eq       = (len_rdata == plen_q);
  assign sts_o.byte_eq      = (char_rdata == pend_rdata);
  assign sts_o.last_byte    = ((PLW'(j_q) + PLW'(1)) == plen_q);
  assign sts_o.out_busy     = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/sit_ctrl.sv]
// ============================================================================
// sit_ctrl: symbol intern table controller
// Sequences character collection, the entry search, insertion and the reply.
// ============================================================================
module sit_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          last_char_i,
  output logic          in_stall_o,
  input  sit_pkg::sts_t sts_i,
  output sit_pkg::cmd_t cmd_o
);

  sit_pkg::ctrl_state_e state_q, state_d;
  logic                 take;

  assign in_stall_o = (state_q != sit_pkg::S_COLLECT);
  assign take       = (state_q == sit_pkg::S_COLLECT) && in_valid_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sit_pkg::S_COLLECT: begin
        if (take && last_char_i) begin
          state_d = sts_i.overlong_now ? sit_pkg::S_RESPOND : sit_pkg::S_LEN_RD;
        end
      end
      sit_pkg::S_LEN_RD: begin
        if (!sts_i.idx_at_count) begin
          state_d = sit_pkg::S_LEN_CMP;
        end else if (sts_i.table_full) begin
          state_d = sit_pkg::S_RESPOND;
        end else begin
          state_d = sit_pkg::S_COPY_RD;
        end
      end
      sit_pkg::S_LEN_CMP: begin
        state_d = sts_i.len_eq ? sit_pkg::S_BYTE_RD : sit_pkg::S_LEN_RD;
      end
      sit_pkg::S_BYTE_RD: begin
        state_d = sit_pkg::S_BYTE_CMP;
      end
      sit_pkg::S_BYTE_CMP: begin
        if (!sts_i.byte_eq) begin
          state_d = sit_pkg::S_LEN_RD;
        end else if (sts_i.last_byte) begin
          state_d = sit_pkg::S_RESPOND;
        end else begin
          state_d = sit_pkg::S_BYTE_RD;
        end
      end
      sit_pkg::S_COPY_RD: begin
        state_d = sit_pkg::S_COPY_WR;
      end
      sit_pkg::S_COPY_WR: begin
        state_d = sts_i.last_byte ? sit_pkg::S_RESPOND : sit_pkg::S_COPY_RD;
      end
      sit_pkg::S_RESPOND: begin
        if (!sts_i.out_busy) begin
          state_d = sit_pkg::S_COLLECT;
        end
      end
      default: state_d = sit_pkg::S_COLLECT;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.res_code = sit_pkg::ST_FOUND;
    unique case (state_q)
      sit_pkg::S_COLLECT: begin
        cmd_o.take_char = take;
        if (take && last_char_i) begin
          if (sts_i.overlong_now) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = sit_pkg::ST_TOO_LONG;
          end else begin
            cmd_o.search_start = 1'b1;
          end
        end
      end
      sit_pkg::S_LEN_RD: begin
        // length read issues from the entry index every cycle
        if (sts_i.idx_at_count) begin
          if (sts_i.table_full) begin
            cmd_o.set_res  = 1'b1;
            cmd_o.res_code = sit_pkg::ST_FULL;
          end else begin
            cmd_o.byte_start = 1'b1;
          end
        end
      end
      sit_pkg::S_LEN_CMP: begin
        if (sts_i.len_eq) begin
          cmd_o.byte_start = 1'b1;
        end else begin
          cmd_o.next_entry = 1'b1;
        end
      end
      sit_pkg::S_BYTE_RD: begin
        // byte reads issue from the byte position
      end
      sit_pkg::S_BYTE_CMP: begin
        if (!sts_i.byte_eq) begin
          cmd_o.next_entry = 1'b1;
        end else if (sts_i.last_byte) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = sit_pkg::ST_FOUND;
        end else begin
          cmd_o.byte_next = 1'b1;
        end
      end
      sit_pkg::S_COPY_RD: begin
        // pending byte read issues from the byte position
      end
      sit_pkg::S_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        if (sts_i.last_byte) begin
          cmd_o.ins_commit = 1'b1;
          cmd_o.set_res    = 1'b1;
          cmd_o.res_code   = sit_pkg::ST_INSERTED;
        end else begin
          cmd_o.byte_next = 1'b1;
        end
      end
      sit_pkg::S_RESPOND: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out      = 1'b1;
          cmd_o.clear_pending = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sit_pkg::S_COLLECT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/symbol_intern_table_top.sv]
// ============================================================================
// symbol_intern_table_top: lexeme interning symbol table
// Collects lexeme characters, searches stored entries in insertion order and
// returns the index of the first equal entry or appends the lexeme, else reports full or too long.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o   | in_item_i  (in_item_t)
//   out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
//
// Characters are taken one per cycle while the input is not stalled. After
// the last character the walk reads and compares the length of each stored
// entry visited, reads and compares each byte on entries of equal length,
// checks for room on reaching the entry count when nothing matches, reads and
// writes each byte when the lexeme is inserted, then hands the result to the
// output register; an overlong lexeme skips the walk. The single read port of
// each store sets this pace. Reset clears the entry count; no clearing pass.
// Input is stalled from the last character until the result is registered; a
// held result does not block collection of the next lexeme.
// ============================================================================
module symbol_intern_table_top #(
  parameter int unsigned MAX_ENTRIES = sit_pkg::MaxEntries,
  parameter int unsigned MAX_LEN     = sit_pkg::MaxLen
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sit_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sit_pkg::out_item_t out_item_o
);

  sit_pkg::cmd_t cmd;
  sit_pkg::sts_t sts;

  // Sequencer
  sit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_char_i(in_item_i.last_char),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stores, counters and compare
  sit_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_LEN    (MAX_LEN)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_byte_i(in_item_i.char_byte),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

[rtl/sit_checker.sv]
// ============================================================================
// sit_checker: symbol intern table port checks
// Assertions on the top-level ports, bound to the top level.
// ============================================================================
module sit_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input sit_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input sit_pkg::out_item_t out_item_o
);

  // A held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o))
    else $error("output payload changed while stalled");

  // The last character starts a search or an overlong reply, either of which stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.last_char) |=> in_stall_o)
    else $error("input not stalled after last character");

  // Inner characters are collected back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_item_i.last_char) |=> !in_stall_o)
    else $error("input stalled during character collection");

  // Full and overlong results carry index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == sit_pkg::ST_FULL ||
                     out_item_o.status == sit_pkg::ST_TOO_LONG))
      |-> (out_item_o.entry_index == '0))
    else $error("nonzero index on a full or overlong result");

endmodule

bind symbol_intern_table_top sit_checker u_sit_checker (.*);

[test/tb_symbol_intern_table_top.sv]
// ============================================================================
// tb_symbol_intern_table_top: self-checking bench for the symbol intern table
// Sends lexemes one character per transaction and predicts each result with
// a behavioral copy of the entry store. A short directed table covers the
// boundaries: case sensitivity, zero bytes, prefixes, the maximum length and
// overlong lexemes. A random part follows, mixing repeats, near misses and
// new lexemes until the table overflows. Sender idling and receiver stalling
// change from phase to phase.
// ============================================================================
module tb_symbol_intern_table_top;

  localparam int unsigned RandItems = 1175;
  localparam int unsigned DirRows   = 17;
  localparam int unsigned DrainCyc  = 200;

  // One directed row: a run of reps copies of ch, last flag on the final one
  typedef struct packed {
    logic [7:0]        ch;
    logic [6:0]        reps;
    logic              last;
    logic              typed;
    logic [6:0]        idx;
    sit_pkg::status_e  st;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall_o;
  sit_pkg::in_item_t  in_item;
  logic               out_valid_o;
  logic               out_stall;
  sit_pkg::out_item_t out_item_o;

  // Predictor state: pending lexeme and stored entries
  logic [7:0] pend_buf [sit_pkg::MaxLen];
  int         pend_len;
  bit         pend_over;
  logic [7:0] tab_chars [sit_pkg::MaxEntries][sit_pkg::MaxLen];
  int         tab_len [sit_pkg::MaxEntries];
  int         tab_count;

  sit_pkg::out_item_t due_results [$];
  sit_pkg::out_item_t head_res;
  int                 fail_count;
  int                 items_sent;
  int                 idle_mode;

  // Directed rows; typed results are read straight off the behavior
  stim_row_t dir_rows [DirRows] = '{
    '{8'h61, 7'd1,  1'b1, 1'b1, 7'd0, sit_pkg::ST_INSERTED},  // first lexeme after reset
    '{8'h41, 7'd1,  1'b1, 1'b1, 7'd1, sit_pkg::ST_INSERTED},  // case differs
    '{8'h61, 7'd1,  1'b1, 1'b1, 7'd0, sit_pkg::ST_FOUND},
    '{8'h00, 7'd1,  1'b1, 1'b1, 7'd2, sit_pkg::ST_INSERTED},  // zero byte is a character
    '{8'h00, 7'd2,  1'b1, 1'b1, 7'd3, sit_pkg::ST_INSERTED},  // same bytes, longer
    '{8'hFF, 7'd1,  1'b1, 1'b1, 7'd4, sit_pkg::ST_INSERTED},
    '{8'h61, 7'd1,  1'b0, 1'b0, 7'd0, sit_pkg::ST_FOUND},
    '{8'h62, 7'd1,  1'b1, 1'b1, 7'd5, sit_pkg::ST_INSERTED},  // extends a stored prefix
    '{8'h61, 7'd1,  1'b0, 1'b0, 7'd0, sit_pkg::ST_FOUND},
    '{8'h62, 7'd1,  1'b1, 1'b0, 7'd0, sit_pkg::ST_FOUND},
    '{8'h00, 7'd1,  1'b1, 1'b1, 7'd2, sit_pkg::ST_FOUND},
    '{8'h78, 7'd64, 1'b1, 1'b1, 7'd6, sit_pkg::ST_INSERTED},  // exactly the entry size
    '{8'h78, 7'd65, 1'b1, 1'b1, 7'd0, sit_pkg::ST_TOO_LONG},
    '{8'h78, 7'd64, 1'b1, 1'b1, 7'd6, sit_pkg::ST_FOUND},
    '{8'h7A, 7'd70, 1'b1, 1'b1, 7'd0, sit_pkg::ST_TOO_LONG},
    '{8'h62, 7'd1,  1'b1, 1'b0, 7'd0, sit_pkg::ST_FOUND},
    '{8'h80, 7'd1,  1'b1, 1'b0, 7'd0, sit_pkg::ST_FOUND}
  };

  symbol_intern_table_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Interns one character; returns 1 when the character completes a lexeme
  function automatic bit intern_char(input sit_pkg::in_item_t it,
                                     output sit_pkg::out_item_t res);
    bit hit;
    res.entry_index = '0;
    res.status      = sit_pkg::ST_FULL;
    if (pend_len < sit_pkg::MaxLen) begin
      pend_buf[pend_len] = it.char_byte;
      pend_len++;
    end else begin
      pend_over = 1'b1;
    end
    if (!it.last_char) return 1'b0;
    if (pend_over) begin
      res.status = sit_pkg::ST_TOO_LONG;
    end else begin
      // first equal entry in insertion order
      for (int e = 0; e < tab_count; e++) begin
        hit = (tab_len[e] == pend_len);
        for (int b = 0; b < pend_len && hit; b++) begin
          if (tab_chars[e][b] != pend_buf[b]) hit = 1'b0;
        end
        if (hit) begin
          res.entry_index = sit_pkg::IndexW'(e);
          res.status      = sit_pkg::ST_FOUND;
          break;
        end
      end
      if (res.status != sit_pkg::ST_FOUND && tab_count < sit_pkg::MaxEntries) begin
        for (int b = 0; b < pend_len; b++) tab_chars[tab_count][b] = pend_buf[b];
        tab_len[tab_count] = pend_len;
        res.entry_index    = sit_pkg::IndexW'(tab_count);
        res.status         = sit_pkg::ST_INSERTED;
        tab_count++;
      end
    end
    pend_len  = 0;
    pend_over = 1'b0;
    return 1'b1;
  endfunction

  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Drives one input transaction and records its expected result
  task automatic send_char(input sit_pkg::in_item_t it, input bit typed,
                           input sit_pkg::out_item_t typed_res);
    sit_pkg::out_item_t res;
    @(negedge clk_i);
    while (chance(idle_mode == 1 ? 86 : (idle_mode == 3 ? 18 : 0))) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (intern_char(it, res)) due_results.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  // Receiver stall, redrawn every cycle
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall = chance(idle_mode == 2 ? 86 : (idle_mode == 3 ? 18 : 0));
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (due_results.size() == 0) begin
        note_error($sformatf("unexpected result index %0d status %0d",
                             out_item_o.entry_index, out_item_o.status));
      end else begin
        head_res = due_results.pop_front();
        if (out_item_o.entry_index !== head_res.entry_index ||
            out_item_o.status !== head_res.status) begin
          note_error($sformatf("expected index %0d status %0d, got index %0d status %0d",
                               head_res.entry_index, head_res.status,
                               out_item_o.entry_index, out_item_o.status));
        end
      end
    end
  end

  initial begin : stimulus
    sit_pkg::in_item_t it;
    logic [7:0]        word_q [$];
    int                r;
    int                k;
    int                len;
    int                pos;
    int                base;
    in_valid   = 1'b0;
    in_item    = '0;
    rst_ni     = 1'b0;
    idle_mode  = 0;
    fail_count = 0;
    items_sent = 0;
    pend_len   = 0;
    pend_over  = 1'b0;
    tab_count  = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    foreach (dir_rows[row]) begin
      for (int n = 1; n <= dir_rows[row].reps; n++) begin
        it.char_byte = dir_rows[row].ch;
        it.last_char = dir_rows[row].last && (n == dir_rows[row].reps);
        send_char(it, dir_rows[row].typed, '{dir_rows[row].idx, dir_rows[row].st});
      end
    end

    // Random lexemes: repeats, near misses of stored entries, new ones
    base = items_sent;
    while (items_sent - base < RandItems) begin
      idle_mode = ((items_sent - base) * 4) / RandItems;
      if (idle_mode > 3) idle_mode = 3;
      word_q.delete();
      r = $urandom_range(0, 99);
      if (r < 50 && tab_count > 0) begin
        k = $urandom_range(0, tab_count - 1);
        for (int b = 0; b < tab_len[k]; b++) word_q.push_back(tab_chars[k][b]);
        if (r >= 35) begin
          case ($urandom_range(0, 2))
            0: begin
              pos = $urandom_range(0, word_q.size() - 1);
              word_q[pos] = word_q[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
            1: begin
              if (word_q.size() > 1) void'(word_q.pop_back());
              else word_q.push_back(8'($urandom_range(0, 255)));
            end
            default: word_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end else begin
        len = chance(3) ? $urandom_range(60, 70) : $urandom_range(1, 4);
        repeat (len) word_q.push_back(8'($urandom_range(0, 255)));
      end
      foreach (word_q[b]) begin
        it.char_byte = word_q[b];
        it.last_char = (b == word_q.size() - 1);
        send_char(it, 1'b0, '0);
      end
    end

    // Drain
    @(negedge clk_i);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** symbol_intern_table_top: PASSED **");
    end else begin
      $display("** symbol_intern_table_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40000000;
    $display("** symbol_intern_table_top: FAILED **");
    $finish;
  end

endmodule
